FILE: hdl/cnsf_pkg.sv
// cnsf_pkg: constants, types and the smoothing arithmetic for the
// cross neighbour smoothing filter; depends on nothing
package cnsf_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CFG_W  = 8;
    localparam int CMP_W  = ((COL_W + 1) > CFG_W) ? (COL_W + 1) : CFG_W;
    localparam int CMPR_W = ((ROW_W + 1) > CFG_W) ? (ROW_W + 1) : CFG_W;
    localparam int SLOTS  = 3;

    localparam logic [1:0] CFG_MAP_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_SMOOTH_MODE = 2'd2;

    localparam logic [1:0] MODE_CLAMP_QUARTER = 2'd0;

    localparam logic [CFG_W-1:0] RST_MAP_WIDTH  = CFG_W'(60);
    localparam logic [CFG_W-1:0] RST_MAP_HEIGHT = CFG_W'(50);

    typedef struct packed {
        logic [7:0] c;
        logic [7:0] l;
        logic [7:0] r;
        logic [7:0] u;
        logic [7:0] d;
    } t_opnd;

    // zero or oversize values fall back to 1 or the maximum
    function automatic logic [CMP_W-1:0] eff_width(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (v == '0) begin
            return CMP_W'(1);
        end else if (ext > CMP_W'(MAX_WIDTH)) begin
            return CMP_W'(MAX_WIDTH);
        end
        return ext;
    endfunction

    function automatic logic [CMPR_W-1:0] eff_height(input logic [CFG_W-1:0] v);
        logic [CMPR_W-1:0] ext;
        ext = CMPR_W'(v);
        if (v == '0) begin
            return CMPR_W'(1);
        end else if (ext > CMPR_W'(MAX_HEIGHT)) begin
            return CMPR_W'(MAX_HEIGHT);
        end
        return ext;
    endfunction

    // absent neighbours arrive as zero
    function automatic logic [7:0] smooth(input logic [1:0] mode, input t_opnd op);
        logic [9:0]  sum;
        logic [10:0] tot;
        logic [8:0]  quarter;
        logic [8:0]  blend;
        sum     = 10'(op.l) + 10'(op.r) + 10'(op.u) + 10'(op.d);
        tot     = 11'(sum) + 11'(op.c);
        quarter = tot[10:2];
        blend   = 9'(sum[9:2]) + 9'(op.c);
        if (mode == MODE_CLAMP_QUARTER) begin
            return (quarter > 9'd255) ? 8'd255 : quarter[7:0];
        end
        return blend[8:1];
    endfunction

endpackage

FILE: hdl/cross_neighbour_smoothing_filter_unit.sv
// cross_neighbour_smoothing_filter_unit: raster four-neighbour smoothing with
// three line stores; depends on cnsf_pkg
// an accepted word's results are held pending, then taken into the output register
// throughput: one result per cycle unless the output stalls; most rows run at one word
// per cycle; on the last row the input stalls while a word's earlier results are taken
// reset: synchronous active-low; clears counters, pending results and output valid
// line stores are not cleared, only rows of the current map are ever read
module cross_neighbour_smoothing_filter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_cell_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_smoothed_value,
    output logic [6:0] o_out_row,
    output logic [6:0] o_out_col,
    output logic       o_run_last,
    output logic       o_frame_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int CW = cnsf_pkg::COL_W;
    localparam int RW = cnsf_pkg::ROW_W;

    // configuration
    logic [cnsf_pkg::CFG_W-1:0] r_map_width;
    logic [cnsf_pkg::CFG_W-1:0] r_map_height;
    logic [1:0]                 r_mode;

    // input side position
    logic [RW-1:0] r_row_cnt;
    logic [CW-1:0] r_col_cnt;
    logic [1:0]    r_rot;

    // line stores
    logic [7:0] r_mem [cnsf_pkg::SLOTS][cnsf_pkg::MAX_WIDTH];

    // work stage
    logic [2:0]    r_pend;
    logic [RW-1:0] r_s_row;
    logic [CW-1:0] r_s_col;
    logic [1:0]    r_s_rot;
    logic          r_col_gt0, r_col_gt1, r_not_last_col, r_row_gt0, r_row_gt1;
    logic [7:0]    r_cur, r_cur1, r_cur2;
    logic [7:0]    r_rd [cnsf_pkg::SLOTS];
    logic [7:0]    r_q  [cnsf_pkg::SLOTS];
    logic [7:0]    r_qq [cnsf_pkg::SLOTS];

    // output register
    logic          r_out_valid;
    logic [7:0]    r_out_val;
    logic [RW-1:0] r_out_row;
    logic [CW-1:0] r_out_col;
    logic          r_out_run_last;
    logic          r_out_frame_last;

    logic [cnsf_pkg::CMP_W-1:0]  w_eff_w;
    logic [cnsf_pkg::CMPR_W-1:0] w_eff_h;
    logic                        w_accept;
    logic                        w_cfg_wr;
    logic                        w_last_col;
    logic                        w_last_row;
    logic [CW-1:0]               w_rd_addr;
    logic [2:0]                  n_new_pend;
    logic                        w_load_ok;
    logic [2:0]                  w_sel;
    logic [2:0]                  w_rest;
    logic                        w_take;
    logic [1:0]                  w_up1, w_up2;
    cnsf_pkg::t_opnd             w_op;
    logic [RW-1:0]               w_res_row;
    logic [CW-1:0]               w_res_col;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;

    assign w_eff_w    = cnsf_pkg::eff_width(r_map_width);
    assign w_eff_h    = cnsf_pkg::eff_height(r_map_height);
    assign w_last_col = (cnsf_pkg::CMP_W'(r_col_cnt) + cnsf_pkg::CMP_W'(1)) == w_eff_w;
    assign w_last_row = (cnsf_pkg::CMPR_W'(r_row_cnt) + cnsf_pkg::CMPR_W'(1)) == w_eff_h;
    // prefetch the next column, wrapping to column 0 for the next row
    assign w_rd_addr  = w_last_col ? '0 : r_col_cnt + CW'(1);

    assign n_new_pend = {w_last_row & w_last_col,
                         w_last_row & (r_col_cnt != '0),
                         r_row_cnt != '0};

    // result selection
    assign w_load_ok = ~r_out_valid | ~i_out_stall;
    assign w_sel     = r_pend & (~r_pend + 3'd1);
    assign w_rest    = r_pend & ~w_sel;
    assign w_take    = (r_pend != '0) & w_load_ok;

    assign o_in_stall = (r_pend != '0) & ~(w_take & (w_rest == '0));
    assign w_accept   = i_in_valid & ~o_in_stall;

    assign w_up1 = (r_s_rot == 2'd0) ? 2'd2 : r_s_rot - 2'd1;
    assign w_up2 = (r_s_rot == 2'd2) ? 2'd0 : r_s_rot + 2'd1;

    always_comb begin
        w_op      = '0;
        w_res_row = r_s_row;
        w_res_col = r_s_col;
        case (w_sel)
            3'b001: begin
                w_op.c    = r_q[w_up1];
                w_op.l    = r_col_gt0 ? r_qq[w_up1] : 8'd0;
                w_op.r    = r_not_last_col ? r_rd[w_up1] : 8'd0;
                w_op.u    = r_row_gt1 ? r_q[w_up2] : 8'd0;
                w_op.d    = r_cur;
                w_res_row = r_s_row - RW'(1);
            end
            3'b010: begin
                w_op.c    = r_cur1;
                w_op.l    = r_col_gt1 ? r_cur2 : 8'd0;
                w_op.r    = r_cur;
                w_op.u    = r_row_gt0 ? r_qq[w_up1] : 8'd0;
                w_res_col = r_s_col - CW'(1);
            end
            3'b100: begin
                w_op.c = r_cur;
                w_op.l = r_col_gt0 ? r_cur1 : 8'd0;
                w_op.u = r_row_gt0 ? r_q[w_up1] : 8'd0;
            end
            default: begin
                w_op = '0;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= cnsf_pkg::RST_MAP_WIDTH;
            r_map_height <= cnsf_pkg::RST_MAP_HEIGHT;
            r_mode       <= cnsf_pkg::MODE_CLAMP_QUARTER;
            r_row_cnt    <= '0;
            r_col_cnt    <= '0;
            r_rot        <= '0;
            r_pend       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (i_cfg_index)
                    cnsf_pkg::CFG_MAP_WIDTH: begin
                        r_map_width <= i_cfg_data;
                        r_row_cnt   <= '0;
                        r_col_cnt   <= '0;
                        r_rot       <= '0;
                    end
                    cnsf_pkg::CFG_MAP_HEIGHT: begin
                        r_map_height <= i_cfg_data;
                        r_row_cnt    <= '0;
                        r_col_cnt    <= '0;
                        r_rot        <= '0;
                    end
                    cnsf_pkg::CFG_SMOOTH_MODE: begin
                        r_mode <= i_cfg_data[1:0];
                    end
                    default: begin
                    end
                endcase
            end else if (w_accept) begin
                if (w_last_col) begin
                    r_col_cnt <= '0;
                    if (w_last_row) begin
                        r_row_cnt <= '0;
                        r_rot     <= '0;
                    end else begin
                        r_row_cnt <= r_row_cnt + RW'(1);
                        r_rot     <= (r_rot == 2'd2) ? 2'd0 : r_rot + 2'd1;
                    end
                end else begin
                    r_col_cnt <= r_col_cnt + CW'(1);
                end
            end

            if (w_accept) begin
                r_pend <= n_new_pend;
            end else if (w_take) begin
                r_pend <= w_rest;
            end

            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // line stores, write-first on a matching address
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_rot][r_col_cnt] <= i_cell_value;
            for (int s = 0; s < cnsf_pkg::SLOTS; s++) begin
                if ((r_rot == 2'(s)) && (w_rd_addr == r_col_cnt)) begin
                    r_rd[s] <= i_cell_value;
                end else begin
                    r_rd[s] <= r_mem[s][w_rd_addr];
                end
            end
        end
    end

    // work stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s_row        <= r_row_cnt;
            r_s_col        <= r_col_cnt;
            r_s_rot        <= r_rot;
            r_col_gt0      <= r_col_cnt != '0;
            r_col_gt1      <= r_col_cnt > CW'(1);
            r_not_last_col <= ~w_last_col;
            r_row_gt0      <= r_row_cnt != '0;
            r_row_gt1      <= r_row_cnt > RW'(1);
            r_cur          <= i_cell_value;
            r_cur1         <= r_cur;
            r_cur2         <= r_cur1;
            for (int s = 0; s < cnsf_pkg::SLOTS; s++) begin
                r_q[s]  <= r_rd[s];
                r_qq[s] <= r_q[s];
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_val        <= cnsf_pkg::smooth(r_mode, w_op);
            r_out_row        <= w_res_row;
            r_out_col        <= w_res_col;
            r_out_run_last   <= w_rest == '0;
            r_out_frame_last <= w_sel[2];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_smoothed_value = r_out_val;
    assign o_out_row        = 7'(r_out_row);
    assign o_out_col        = 7'(r_out_col);
    assign o_run_last       = r_out_run_last;
    assign o_frame_last     = r_out_frame_last;

    a_accept_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ($countones(r_pend) <= 1))
        else $error("word accepted with more than one result pending");

    a_row0_rot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row_cnt == '0) |-> (r_rot == 2'd0))
        else $error("line rotation not home on the first row");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnsf_pkg::CMP_W'(r_col_cnt) < w_eff_w)
        else $error("column count beyond map width");

    a_frame_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_frame_last) |-> r_out_run_last)
        else $error("frame end not flagged as last of its run");

    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pend != '0) && r_out_valid && i_out_stall) |=> $stable(r_pend))
        else $error("pending results moved while output stalled");

endmodule
